### design/gmr_pkg.sv
package gmr_pkg;

  // Parameter defaults
  localparam int MAX_DIM_DEF   = 16;
  localparam int MAX_CELLS_DEF = 256;

  // Configuration port
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam int CFG_W       = 5;
  localparam int SETTLE_CYC  = 2;
  localparam logic [CFG_W-1:0] GRID_W_RESET = 5'd14;
  localparam logic [CFG_W-1:0] GRID_H_RESET = 5'd8;

  // Register indexes (paddr word index)
  localparam logic [PADDR_W-3:0] REG_GRID_WIDTH  = 1'd0;
  localparam logic [PADDR_W-3:0] REG_GRID_HEIGHT = 1'd1;

  // Op codes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // Wall bit positions in the wall store
  localparam int WB_TOP    = 0;
  localparam int WB_BOTTOM = 1;
  localparam int WB_LEFT   = 2;
  localparam int WB_RIGHT  = 3;

  // Neighbor probe order
  localparam logic [1:0] DIR_TOP    = 2'd0;
  localparam logic [1:0] DIR_BOTTOM = 2'd1;
  localparam logic [1:0] DIR_LEFT   = 2'd2;
  localparam logic [1:0] DIR_RIGHT  = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] cell_index;
    logic       wall_top;
    logic       wall_bottom;
    logic       wall_left;
    logic       wall_right;
  } in_t;

  typedef struct packed {
    logic [8:0] reached_count;
    logic       all_reached;
    logic       cell_reached;
  } out_t;

endpackage

### design/grid_maze_reachability_top.sv
// Grid maze reachability block.
// Input channel (in_valid/in_ready/in_word) takes one word per op:
//   load   - writes the four wall bits of cell_index; result is all zeros.
//   run    - clears the visited map and flood-fills from the bottom-left
//            cell; result carries reached_count and all_reached.
//   query  - result carries the last run's count/flag and cell_reached.
//   op 3   - taken and dropped, no result.
// Output channel (out_valid/out_ready/out_word) has a one-word output
// register; a new word is taken while a finished result waits there.
// Steps per word:
//   load   straight to the output register when it is free, else waits.
//   query  visited-map read, result, output.
//   run    clear all MAX_CELLS visited-map entries, then per reached
//          cell a stack pop, wall read, four neighbor probes on the
//          single visited-map port and a last probe, then finish.
// Reset (rst, synchronous) restores the registers to width 14, height 8
// and then sweeps the whole visited map with in_ready low.
// A config write holds in_ready low while geometry settles.
// A stalled receiver only holds the output word; the engine waits in place.
module grid_maze_reachability_top #(
  parameter int MAX_DIM   = gmr_pkg::MAX_DIM_DEF,
  parameter int MAX_CELLS = gmr_pkg::MAX_CELLS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gmr_pkg::PADDR_W-1:0] paddr,
  input  logic [gmr_pkg::PDATA_W-1:0] pwdata,
  output logic [gmr_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  gmr_pkg::in_t                in_word,
  output logic                        out_valid,
  input  logic                        out_ready,
  output gmr_pkg::out_t               out_word
);

  import gmr_pkg::*;

  localparam int DCNT_W = $clog2(MAX_DIM+1);
  localparam int CNT_W  = $clog2(MAX_CELLS+1);

  // effective geometry after saturation and row fitting
  logic              geo_ok;
  logic [DCNT_W-1:0] eff_w;
  logic [DCNT_W-1:0] eff_h;
  logic [CNT_W-1:0]  cells;

  gmr_cfg #(.MAX_DIM(MAX_DIM), .MAX_CELLS(MAX_CELLS)) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .geo_ok  (geo_ok),
    .eff_w   (eff_w),
    .eff_h   (eff_h),
    .cells   (cells)
  );

  // wall store, visited map and pending stack live in the fill engine
  gmr_fill #(.MAX_DIM(MAX_DIM), .MAX_CELLS(MAX_CELLS)) u_fill (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .geo_ok    (geo_ok),
    .eff_w     (eff_w),
    .eff_h     (eff_h),
    .cells     (cells)
  );

endmodule

### design/gmr_ram.sv
module gmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/gmr_cfg.sv
module gmr_cfg #(
  parameter int MAX_DIM   = 16,
  parameter int MAX_CELLS = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [gmr_pkg::PADDR_W-1:0]         paddr,
  input  logic [gmr_pkg::PDATA_W-1:0]         pwdata,
  output logic [gmr_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready,
  output logic                                geo_ok,
  output logic [$clog2(MAX_DIM+1)-1:0]        eff_w,
  output logic [$clog2(MAX_DIM+1)-1:0]        eff_h,
  output logic [$clog2(MAX_CELLS+1)-1:0]      cells
);

  import gmr_pkg::*;

  localparam int DCNT_W = $clog2(MAX_DIM+1);
  localparam int CNT_W  = $clog2(MAX_CELLS+1);

  logic [CFG_W-1:0]       grid_width;
  logic [CFG_W-1:0]       grid_height;
  logic [1:0]             settle;
  logic                   wr;
  logic [PADDR_W-3:0]     reg_sel;
  logic [DCNT_W-1:0]      w_sat;
  logic [DCNT_W-1:0]      h_sat;
  logic [DCNT_W-1:0]      h_fit;
  logic [CNT_W-1:0]       cap;
  logic [CNT_W-1:0]       cap_tab [MAX_DIM+1];
  logic [2*DCNT_W-1:0]    area;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign reg_sel = paddr[PADDR_W-1:2];
  assign geo_ok  = (settle == 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_W_RESET;
      grid_height <= GRID_H_RESET;
      settle      <= 2'(SETTLE_CYC);
    end else begin
      if (wr) begin
        unique case (reg_sel)
          REG_GRID_WIDTH:  grid_width  <= pwdata[CFG_W-1:0];
          REG_GRID_HEIGHT: grid_height <= pwdata[CFG_W-1:0];
          default: ;
        endcase
      end
      if (wr) begin
        settle <= 2'(SETTLE_CYC);
      end else if (settle != 2'd0) begin
        settle <= settle - 2'd1;
      end
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_GRID_WIDTH:  prdata = PDATA_W'(grid_width);
      REG_GRID_HEIGHT: prdata = PDATA_W'(grid_height);
      default:         prdata = '0;
    endcase
  end

  // rows that fit for a given width: MAX_CELLS / w
  assign cap_tab[0] = '0;
  for (genvar g = 1; g <= MAX_DIM; g++) begin : g_cap
    localparam int Q = MAX_CELLS / g;
    assign cap_tab[g] = CNT_W'(Q);
  end

  always_comb begin
    if (grid_width == '0) begin
      w_sat = DCNT_W'(1);
    end else if (32'(grid_width) > 32'(MAX_DIM)) begin
      w_sat = DCNT_W'(MAX_DIM);
    end else begin
      w_sat = DCNT_W'(grid_width);
    end
    if (grid_height == '0) begin
      h_sat = DCNT_W'(1);
    end else if (32'(grid_height) > 32'(MAX_DIM)) begin
      h_sat = DCNT_W'(MAX_DIM);
    end else begin
      h_sat = DCNT_W'(grid_height);
    end
    cap   = cap_tab[w_sat];
    h_fit = (32'(h_sat) > 32'(cap)) ? DCNT_W'(cap) : h_sat;
  end

  assign area = (2*DCNT_W)'(eff_w) * (2*DCNT_W)'(eff_h);

  // two-stage geometry: saturate/fit, then cell count
  always_ff @(posedge clk) begin
    eff_w <= w_sat;
    eff_h <= h_fit;
    cells <= CNT_W'(area);
  end

endmodule

### design/gmr_fill.sv
module gmr_fill #(
  parameter int MAX_DIM   = 16,
  parameter int MAX_CELLS = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  gmr_pkg::in_t                   in_word,
  output logic                           out_valid,
  input  logic                           out_ready,
  output gmr_pkg::out_t                  out_word,
  input  logic                           geo_ok,
  input  logic [$clog2(MAX_DIM+1)-1:0]   eff_w,
  input  logic [$clog2(MAX_DIM+1)-1:0]   eff_h,
  input  logic [$clog2(MAX_CELLS+1)-1:0] cells
);

  import gmr_pkg::*;

  localparam int DIM_W  = $clog2(MAX_DIM);
  localparam int DCNT_W = $clog2(MAX_DIM+1);
  localparam int CELL_W = $clog2(MAX_CELLS);
  localparam int CNT_W  = $clog2(MAX_CELLS+1);

  typedef struct packed {
    logic [DIM_W-1:0]  y;
    logic [DIM_W-1:0]  x;
    logic [CELL_W-1:0] idx;
  } ent_t;

  localparam int ENT_W = $bits(ent_t);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CLEAR = 9'b000000010,
    S_SEED  = 9'b000000100,
    S_POP   = 9'b000001000,
    S_WALL  = 9'b000010000,
    S_DIR   = 9'b000100000,
    S_LAST  = 9'b001000000,
    S_QRD   = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_t;

  state_t            state, state_next;
  logic              clr_run;
  logic [CNT_W-1:0]  clr_cnt;
  logic [CNT_W-1:0]  sp;
  logic [CNT_W-1:0]  sp_m1;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  last_count;
  logic              last_all;
  ent_t              cur;
  ent_t              chk;
  ent_t              nb;
  ent_t              seed;
  ent_t              stk_ent;
  logic              chk_en;
  logic              nb_ok;
  logic [1:0]        dir;
  logic              q_ok;
  out_t              res;

  logic              acc;
  logic              slot_free;
  logic              clr_last;
  logic              mark;
  logic              no_rows;
  logic              fin_all;
  logic              idx_ok;
  logic              load_direct;
  logic              emit_fire;
  logic [CELL_W-1:0] in_idx;

  logic              wall_we;
  logic [3:0]        wall_wdata;
  logic [CELL_W-1:0] wall_raddr;
  logic [3:0]        walls;

  logic              vis_we;
  logic [CELL_W-1:0] vis_waddr;
  logic              vis_wdata;
  logic [CELL_W-1:0] vis_raddr;
  logic              vis_rdata;

  logic              stk_we;
  logic [CELL_W-1:0] stk_waddr;
  logic [ENT_W-1:0]  stk_wdata;
  logic [ENT_W-1:0]  stk_rdata;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE) && geo_ok;
  assign acc       = in_valid && in_ready;
  assign in_idx    = CELL_W'(in_word.cell_index);
  assign idx_ok    = 32'(in_word.cell_index) < 32'(MAX_CELLS);
  assign clr_last  = (clr_cnt == CNT_W'(MAX_CELLS - 1));
  assign no_rows   = (eff_h == '0);
  assign sp_m1     = sp - CNT_W'(1);
  assign fin_all   = (cnt == cells);
  assign stk_ent   = ent_t'(stk_rdata);

  // neighbor enters only if unvisited; chk_en is cleared in the wall-read state
  assign mark = ((state == S_DIR) || (state == S_LAST)) && chk_en && !vis_rdata;

  assign seed.y   = DIM_W'(eff_h - DCNT_W'(1));
  assign seed.x   = '0;
  assign seed.idx = CELL_W'(cells - CNT_W'(eff_w));

  // neighbor of the current cell in probe direction dir
  always_comb begin
    nb = cur;
    unique case (dir)
      DIR_TOP: begin
        nb_ok  = !walls[WB_TOP] && (cur.y != '0);
        nb.y   = cur.y - DIM_W'(1);
        nb.idx = cur.idx - CELL_W'(eff_w);
      end
      DIR_BOTTOM: begin
        nb_ok  = !walls[WB_BOTTOM] && ((DCNT_W'(cur.y) + DCNT_W'(1)) < eff_h);
        nb.y   = cur.y + DIM_W'(1);
        nb.idx = cur.idx + CELL_W'(eff_w);
      end
      DIR_LEFT: begin
        nb_ok  = !walls[WB_LEFT] && (cur.x != '0);
        nb.x   = cur.x - DIM_W'(1);
        nb.idx = cur.idx - CELL_W'(1);
      end
      DIR_RIGHT: begin
        nb_ok  = !walls[WB_RIGHT] && ((DCNT_W'(cur.x) + DCNT_W'(1)) < eff_w);
        nb.x   = cur.x + DIM_W'(1);
        nb.idx = cur.idx + CELL_W'(1);
      end
      default: nb_ok = 1'b0;
    endcase
  end

  // wall store
  assign wall_we    = acc && (in_word.op == OP_LOAD) && idx_ok;
  assign wall_wdata = {in_word.wall_right, in_word.wall_left,
                       in_word.wall_bottom, in_word.wall_top};
  assign wall_raddr = (state == S_WALL) ? stk_ent.idx : cur.idx;

  // visited map
  always_comb begin
    vis_we    = mark;
    vis_waddr = chk.idx;
    vis_wdata = 1'b1;
    unique case (state)
      S_CLEAR: begin
        vis_we    = 1'b1;
        vis_waddr = clr_cnt[CELL_W-1:0];
        vis_wdata = 1'b0;
      end
      S_SEED: begin
        vis_we    = !no_rows;
        vis_waddr = seed.idx;
      end
      default: ;
    endcase
  end

  assign vis_raddr = (state == S_IDLE) ? in_idx : nb.idx;

  // pending stack
  assign stk_we    = ((state == S_SEED) && !no_rows) || mark;
  assign stk_waddr = (state == S_SEED) ? '0 : sp[CELL_W-1:0];
  assign stk_wdata = (state == S_SEED) ? seed : chk;

  gmr_ram #(.WIDTH(4), .DEPTH(MAX_CELLS)) u_wall_ram (
    .clk   (clk),
    .we    (wall_we),
    .waddr (in_idx),
    .wdata (wall_wdata),
    .raddr (wall_raddr),
    .rdata (walls)
  );

  gmr_ram #(.WIDTH(1), .DEPTH(MAX_CELLS)) u_vis_ram (
    .clk   (clk),
    .we    (vis_we),
    .waddr (vis_waddr),
    .wdata (vis_wdata),
    .raddr (vis_raddr),
    .rdata (vis_rdata)
  );

  gmr_ram #(.WIDTH(ENT_W), .DEPTH(MAX_CELLS)) u_stk_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (sp_m1[CELL_W-1:0]),
    .rdata (stk_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (acc) begin
          case (in_word.op)
            OP_LOAD:  if (!slot_free) state_next = S_EMIT;
            OP_RUN:   state_next = S_CLEAR;
            OP_QUERY: state_next = S_QRD;
            default: ;
          endcase
        end
      end
      S_CLEAR: if (clr_last) state_next = clr_run ? S_SEED : S_IDLE;
      S_SEED:  state_next = no_rows ? S_EMIT : S_POP;
      S_POP:   state_next = (sp == '0) ? S_EMIT : S_WALL;
      S_WALL:  state_next = S_DIR;
      S_DIR:   if (dir == DIR_RIGHT) state_next = S_LAST;
      S_LAST:  state_next = S_POP;
      S_QRD:   state_next = S_EMIT;
      S_EMIT:  if (slot_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_run    <= 1'b0;
      clr_cnt    <= '0;
      sp         <= '0;
      cnt        <= '0;
      last_count <= '0;
      last_all   <= 1'b0;
      chk_en     <= 1'b0;
      dir        <= DIR_TOP;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            case (in_word.op)
              OP_LOAD: res <= '0;
              OP_RUN: begin
                clr_run <= 1'b1;
                clr_cnt <= '0;
              end
              OP_QUERY: q_ok <= 32'(in_word.cell_index) < 32'(cells);
              default: ;
            endcase
          end
        end
        S_CLEAR: clr_cnt <= clr_last ? '0 : clr_cnt + CNT_W'(1);
        S_SEED: begin
          if (no_rows) begin
            last_count        <= '0;
            last_all          <= 1'b1;
            res.reached_count <= '0;
            res.all_reached   <= 1'b1;
            res.cell_reached  <= 1'b0;
          end else begin
            sp  <= CNT_W'(1);
            cnt <= CNT_W'(1);
          end
        end
        S_POP: begin
          if (sp == '0) begin
            last_count        <= cnt;
            last_all          <= fin_all;
            res.reached_count <= 9'(cnt);
            res.all_reached   <= fin_all;
            res.cell_reached  <= 1'b0;
          end else begin
            sp <= sp_m1;
          end
        end
        S_WALL: begin
          cur    <= stk_ent;
          chk_en <= 1'b0;
          dir    <= DIR_TOP;
        end
        S_DIR: begin
          chk_en <= nb_ok;
          chk    <= nb;
          dir    <= dir + 2'd1;
        end
        S_QRD: begin
          res.reached_count <= 9'(last_count);
          res.all_reached   <= last_all;
          res.cell_reached  <= q_ok && vis_rdata;
        end
        default: ;
      endcase
      // a mark pushes on top of whatever the probe sequence left
      if (mark) begin
        sp  <= sp + CNT_W'(1);
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  // output register
  assign load_direct = acc && (in_word.op == OP_LOAD) && slot_free;
  assign emit_fire   = (state == S_EMIT) && slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_direct || emit_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_direct) begin
      out_word <= '0;
    end else if (emit_fire) begin
      out_word <= res;
    end
  end

endmodule

### design/gmr_checker.sv
module gmr_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input gmr_pkg::in_t                in_word,
  input logic                        out_valid,
  input logic                        out_ready,
  input gmr_pkg::out_t               out_word
);

  import gmr_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("output word changed while stalled");

  // a run occupies the engine, no word taken right after it
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_word.op == OP_RUN) |=> !in_ready)
    else $error("word accepted right after a run");

  // a reached cell implies the last run reached something
  a_reached_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.cell_reached |-> out_word.reached_count != '0)
    else $error("cell reached with zero count");

  // reset empties the output and starts the clearing sweep
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_ready)
    else $error("block not quiet after reset");

endmodule

bind grid_maze_reachability_top gmr_checker u_gmr_checker (.*);
